[design/interval_set_merge_store_unit_assert.svh]
// assertion macros for the interval store, clocked on clk, held off during reset
`ifndef INTERVAL_SET_MERGE_STORE_UNIT_ASSERT_SVH
`define INTERVAL_SET_MERGE_STORE_UNIT_ASSERT_SVH

// same-cycle implication
`define ISMS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("isms check failed");

// next-cycle implication
`define ISMS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("isms check failed");

`endif

[design/isms_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package isms_pkg;

    localparam int DEF_TABLE_COUNT   = 10;
    localparam int DEF_MAX_INTERVALS = 16;

    localparam logic [1:0] ACT_ADD     = 2'd0;
    localparam logic [1:0] ACT_REMOVE  = 2'd1;
    localparam logic [1:0] ACT_REPLACE = 2'd2;

    localparam logic [2:0] ST_DONE     = 3'd0;
    localparam logic [2:0] ST_EMPTY    = 3'd1;
    localparam logic [2:0] ST_NO_TABLE = 3'd2;
    localparam logic [2:0] ST_NO_MATCH = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;

    typedef struct packed {
        logic [1:0]  action;
        logic [3:0]  table_id;
        logic [31:0] start_time;
        logic [31:0] end_time;
    } cmd_word_t;

    typedef struct packed {
        logic [2:0] status;
        logic [4:0] range_count;
    } rsp_word_t;

    typedef struct packed {
        logic [31:0] start_time;
        logic [31:0] end_time;
    } ivl_t;

    // controller to datapath
    typedef struct packed {
        logic       load;
        logic       start_search;
        logic       search_step;
        logic       start_merge;
        logic       merge_ins;
        logic       merge_skip;
        logic       merge_step;
        logic       flush;
        logic       set_code;
        logic [2:0] code;
        logic       publish;
    } ctl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_add;
        logic is_rem;
        logic is_rep;
        logic empty;
        logic tbl_bad;
        logic full;
        logic at_end;
        logic hit;
        logic merge_end;
    } ctl_stat_t;

endpackage

`default_nettype wire

[design/isms_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none

module isms_datapath #(
    parameter int TABLE_COUNT   = isms_pkg::DEF_TABLE_COUNT,
    parameter int MAX_INTERVALS = isms_pkg::DEF_MAX_INTERVALS
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire isms_pkg::cmd_word_t cmd_data,
    input  wire isms_pkg::ctl_cmd_t  ctl,
    output isms_pkg::ctl_stat_t      stat,
    output isms_pkg::rsp_word_t      rsp_data
);

    localparam int CNT_W  = $clog2(MAX_INTERVALS + 1);
    localparam int DEPTH  = TABLE_COUNT * MAX_INTERVALS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int TBL_W  = (TABLE_COUNT > 1) ? $clog2(TABLE_COUNT) : 1;

    isms_pkg::cmd_word_t in_reg;
    isms_pkg::rsp_word_t rsp_reg;
    isms_pkg::ivl_t      mem [DEPTH];
    isms_pkg::ivl_t      rdata_reg;
    isms_pkg::ivl_t      x;

    logic [ADDR_W-1:0] base_reg;
    logic [ADDR_W-1:0] raddr;
    logic [ADDR_W-1:0] waddr;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  w_reg, w_next;
    logic [CNT_W-1:0]  skip_idx_reg;
    logic [CNT_W-1:0]  cnt_reg [TABLE_COUNT];
    logic [CNT_W-1:0]  n;
    logic              skip_reg, pend_reg;
    logic              cur_v_reg, cur_v_next;
    logic [31:0]       cur_s_reg, cur_s_next, cur_e_reg, cur_e_next;
    logic [2:0]        code_reg;
    logic [3:0]        tsel;
    logic [TBL_W-1:0]  tidx;
    logic              tbl_ok, at_end, is_skip, take_new, use_old, adv_old;
    logic              do_merge, joins, we;

    assign tsel   = in_reg.table_id - 4'd1;
    assign tidx   = tsel[TBL_W-1:0];
    assign tbl_ok = (in_reg.table_id != 4'd0) && (in_reg.table_id <= TABLE_COUNT);
    assign n      = tbl_ok ? cnt_reg[tidx] : '0;

    // merge step: new interval goes in start order, matched entry is dropped
    assign at_end   = (idx_reg == n);
    assign is_skip  = skip_reg && (idx_reg == skip_idx_reg);
    assign take_new = pend_reg && (at_end || (in_reg.start_time <= rdata_reg.start_time));
    assign adv_old  = !take_new && !at_end;
    assign use_old  = adv_old && !is_skip;
    assign x        = take_new ? isms_pkg::ivl_t'({in_reg.start_time, in_reg.end_time})
                               : rdata_reg;
    assign do_merge = ctl.merge_step && (take_new || use_old);
    assign joins    = cur_v_reg && (x.start_time <= cur_e_reg);
    assign we       = (do_merge && cur_v_reg && !joins) || (ctl.flush && cur_v_reg);
    assign w_next   = ctl.start_merge ? '0 : (we ? w_reg + 1'b1 : w_reg);
    assign waddr    = base_reg + ADDR_W'(w_reg);
    assign raddr    = base_reg + ADDR_W'(idx_next);

    always_comb
    begin
        if (ctl.start_search || ctl.start_merge)
        begin
            idx_next = '0;
        end
        else if (ctl.search_step || (ctl.merge_step && adv_old))
        begin
            idx_next = idx_reg + 1'b1;
        end
        else
        begin
            idx_next = idx_reg;
        end
    end

    always_comb
    begin
        cur_v_next = cur_v_reg;
        cur_s_next = cur_s_reg;
        cur_e_next = cur_e_reg;
        if (ctl.start_merge)
        begin
            cur_v_next = 1'b0;
        end
        else if (do_merge)
        begin
            if (joins)
            begin
                cur_e_next = (x.end_time > cur_e_reg) ? x.end_time : cur_e_reg;
            end
            else
            begin
                cur_v_next = 1'b1;
                cur_s_next = x.start_time;
                cur_e_next = x.end_time;
            end
        end
    end

    always_comb
    begin
        stat.is_add    = (in_reg.action == isms_pkg::ACT_ADD);
        stat.is_rem    = (in_reg.action == isms_pkg::ACT_REMOVE);
        stat.is_rep    = (in_reg.action == isms_pkg::ACT_REPLACE);
        stat.empty     = (stat.is_add || stat.is_rep) && (in_reg.start_time >= in_reg.end_time);
        stat.tbl_bad   = !tbl_ok;
        stat.full      = (n >= CNT_W'(MAX_INTERVALS));
        stat.at_end    = at_end;
        stat.hit       = !at_end && (stat.is_rem
            ? ((rdata_reg.start_time == in_reg.start_time) &&
               (rdata_reg.end_time == in_reg.end_time))
            : ((rdata_reg.start_time < in_reg.end_time) &&
               (rdata_reg.end_time > in_reg.start_time)));
        stat.merge_end = at_end && !pend_reg;
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= '{start_time: cur_s_reg, end_time: cur_e_reg};
        end
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            in_reg   <= cmd_data;
            base_reg <= ADDR_W'(ADDR_W'(cmd_data.table_id - 4'd1) * ADDR_W'(MAX_INTERVALS));
        end
        if (ctl.start_merge)
        begin
            skip_reg     <= ctl.merge_skip;
            skip_idx_reg <= idx_reg;
        end
        if (ctl.set_code)
        begin
            code_reg <= ctl.code;
        end
        if (ctl.publish)
        begin
            rsp_reg.status      <= code_reg;
            rsp_reg.range_count <= 5'(n);
        end
        idx_reg   <= idx_next;
        w_reg     <= w_next;
        cur_s_reg <= cur_s_next;
        cur_e_reg <= cur_e_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_COUNT; i++)
            begin
                cnt_reg[i] <= '0;
            end
            pend_reg  <= 1'b0;
            cur_v_reg <= 1'b0;
        end
        else
        begin
            if (ctl.flush && tbl_ok)
            begin
                cnt_reg[tidx] <= w_next;
            end
            if (ctl.start_merge)
            begin
                pend_reg <= ctl.merge_ins;
            end
            else if (ctl.merge_step && take_new)
            begin
                pend_reg <= 1'b0;
            end
            cur_v_reg <= cur_v_next;
        end
    end

    assign rsp_data = rsp_reg;

endmodule

`default_nettype wire

[design/isms_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module isms_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cmd_valid,
    output logic                     cmd_ready,
    output logic                     rsp_valid,
    input  wire logic                rsp_ready,
    input  wire isms_pkg::ctl_stat_t stat,
    output isms_pkg::ctl_cmd_t       ctl
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_EVAL   = 5'b00010,
        S_SEARCH = 5'b00100,
        S_MERGE  = 5'b01000,
        S_FINISH = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || rsp_ready;
    assign cmd_ready = (state_reg == S_IDLE);
    assign rsp_valid = out_valid_reg;

    always_comb
    begin
        ctl        = '0;
        ctl.code   = isms_pkg::ST_DONE;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                ctl.set_code = 1'b1;
                priority if (stat.empty)
                begin
                    ctl.code   = isms_pkg::ST_EMPTY;
                    state_next = S_FINISH;
                end
                else if (stat.tbl_bad)
                begin
                    ctl.code   = isms_pkg::ST_NO_TABLE;
                    state_next = S_FINISH;
                end
                else if (stat.is_add && stat.full)
                begin
                    ctl.code   = isms_pkg::ST_FULL;
                    state_next = S_FINISH;
                end
                else if (stat.is_add)
                begin
                    ctl.start_merge = 1'b1;
                    ctl.merge_ins   = 1'b1;
                    state_next      = S_MERGE;
                end
                else if (stat.is_rem || stat.is_rep)
                begin
                    ctl.start_search = 1'b1;
                    state_next       = S_SEARCH;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_SEARCH:
            begin
                priority if (stat.at_end)
                begin
                    ctl.set_code = 1'b1;
                    ctl.code     = isms_pkg::ST_NO_MATCH;
                    state_next   = S_FINISH;
                end
                else if (stat.hit)
                begin
                    ctl.start_merge = 1'b1;
                    ctl.merge_skip  = 1'b1;
                    ctl.merge_ins   = stat.is_rep;
                    state_next      = S_MERGE;
                end
                else
                begin
                    ctl.search_step = 1'b1;
                end
            end
            S_MERGE:
            begin
                if (stat.merge_end)
                begin
                    ctl.flush  = 1'b1;
                    state_next = S_FINISH;
                end
                else
                begin
                    ctl.merge_step = 1'b1;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    ctl.publish = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (ctl.publish)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

[design/interval_set_merge_store_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// channel   dir   handshake              word
// cmd       in    cmd_valid/cmd_ready    action, table_id, start_time, end_time
// rsp       out   rsp_valid/rsp_ready    status, range_count
//
// add runs a merge pass alone; remove and replace run a search pass, then the merge pass
// both passes step through the table's stored entries via a single registered memory
// read port; the merge pass rewrites the table in place
// invalid or rejected words go straight to the result, with no search or merge pass
// reset clears the per-table counts and merge flags, not the interval memory, which needs no clearing
// a finished word waits in the output register, a new cmd word is taken meanwhile

module interval_set_merge_store_unit #(
    parameter int TABLE_COUNT   = isms_pkg::DEF_TABLE_COUNT,
    parameter int MAX_INTERVALS = isms_pkg::DEF_MAX_INTERVALS
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cmd_valid,
    output logic                     cmd_ready,
    input  wire isms_pkg::cmd_word_t cmd_data,
    output logic                     rsp_valid,
    input  wire logic                rsp_ready,
    output isms_pkg::rsp_word_t      rsp_data
);

`include "interval_set_merge_store_unit_assert.svh"

    // command and status between sequencer and datapath
    isms_pkg::ctl_cmd_t  ctl;
    isms_pkg::ctl_stat_t stat;

    // sequencer: decode, search, merge, result hand-off
    isms_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .stat      (stat),
        .ctl       (ctl)
    );

    // interval memory, per-table counts, streaming merge unit
    isms_datapath #(
        .TABLE_COUNT   (TABLE_COUNT),
        .MAX_INTERVALS (MAX_INTERVALS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_data (cmd_data),
        .ctl      (ctl),
        .stat     (stat),
        .rsp_data (rsp_data)
    );

    // one word in flight: busy right after a cmd word is taken
    `ISMS_ASSERT_NEXT(a_busy_after_accept, cmd_valid && cmd_ready, !cmd_ready)
    // a result is only loaded when the output register is free
    `ISMS_ASSERT_NOW(a_publish_free, ctl.publish, !rsp_valid || rsp_ready)
    // a loaded result is offered on the next cycle
    `ISMS_ASSERT_NEXT(a_publish_valid, ctl.publish, rsp_valid)

endmodule

`default_nettype wire
